@@ design/rcerr_pkg.sv @@
// Shared types and constants of the correlated ratio error block.
`default_nettype none
package rcerr_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SUBSET = 2'd0;
  localparam mode_t MODE_FULL   = 2'd1;
  localparam mode_t MODE_DIFF   = 2'd2;
  localparam mode_t MODE_UNCORR = 2'd3;

  localparam mode_t MODE_RESET  = MODE_FULL;

  localparam int LIMB_BITS     = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef struct packed {
    logic vld;
    logic skip;
  } pipe_ctl_t;

endpackage
`default_nettype wire

@@ design/rcerr_in_if.sv @@
// Input channel: one histogram bin per beat.
`default_nettype none
interface rcerr_in_if #(
  parameter int VB = 32
) ();
  logic          valid;
  logic          ready;
  logic [VB-1:0] numerator_count;
  logic [VB-1:0] numerator_sigma;
  logic [VB-1:0] denominator_count;
  logic [VB-1:0] denominator_sigma;
  logic [VB-1:0] ratio_content;

  modport source (
    output valid, numerator_count, numerator_sigma, denominator_count,
           denominator_sigma, ratio_content,
    input  ready
  );
  modport sink (
    input  valid, numerator_count, numerator_sigma, denominator_count,
           denominator_sigma, ratio_content,
    output ready
  );
endinterface
`default_nettype wire

@@ design/rcerr_out_if.sv @@
// Result channel: one propagated ratio error per beat.
`default_nettype none
interface rcerr_out_if #(
  parameter int VB = 32
) ();
  logic          valid;
  logic          ready;
  logic [VB-1:0] ratio_sigma;
  logic          fallback_used;
  logic          bin_skipped;
  logic          saturated;

  modport source (
    output valid, ratio_sigma, fallback_used, bin_skipped, saturated,
    input  ready
  );
  modport sink (
    input  valid, ratio_sigma, fallback_used, bin_skipped, saturated,
    output ready
  );
endinterface
`default_nettype wire

@@ design/rcerr_mul.sv @@
// Two-stage multiplier built from registered limb products and a summing stage.
`default_nettype none
module rcerr_mul import rcerr_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA    = (AW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int NB    = (BW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int EA    = NA * LIMB_BITS;
  localparam int EB    = NB * LIMB_BITS;
  localparam int ACC_W = EA + EB;

  logic [EA-1:0]          a_ext;
  logic [EB-1:0]          b_ext;
  logic [2*LIMB_BITS-1:0] pp_r [NA][NB];
  logic [ACC_W-1:0]       acc;
  logic [AW+BW-1:0]       p_r;

  assign a_ext = EA'(a);
  assign b_ext = EB'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= a_ext[i*LIMB_BITS +: LIMB_BITS] * b_ext[j*LIMB_BITS +: LIMB_BITS];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (ACC_W'(pp_r[i][j]) << (LIMB_BITS * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

@@ design/rcerr_prep.sv @@
// Front end: forms the radicand and the squared denominator of one bin.
`default_nettype none
module rcerr_prep import rcerr_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  mode_t                     mode,
  input  logic                      in_vld,
  input  logic [VALUE_BITS-1:0]     num_cnt,
  input  logic [VALUE_BITS-1:0]     num_sig,
  input  logic [VALUE_BITS-1:0]     den_cnt,
  input  logic [VALUE_BITS-1:0]     den_sig,
  input  logic [VALUE_BITS-1:0]     ratio,
  output logic [6*VALUE_BITS+2:0]   m,
  output logic [4*VALUE_BITS-1:0]   dsq,
  output pipe_ctl_t                 ctl
);

  localparam int V  = VALUE_BITS;
  localparam int MW = 6 * V + 3;
  localparam int DW = 4 * V;

  logic [2*V-1:0] x, y, d, ss, rr, sa2, sb2, aa2;
  logic [2*V-1:0] corr, d2;
  logic [4*V-1:0] xx, yy, cd, dd;
  logic [6*V:0]   m1;

  pipe_ctl_t      ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r, ctl8_r;
  logic [2*V-1:0] rr3_r, rr4_r, rr5_r;
  logic [2*V-1:0] d23_r, d24_r, d25_r, d26_r, d27_r;
  logic [2*V-1:0] aa3_r, aa4_r;
  logic [4*V:0]   n5_r;
  logic [DW-1:0]  dsq5_r, dsq6_r, dsq7_r, dsq8_r;
  logic [MW-1:0]  m8_r;
  logic [4*V:0]   nsum;

  rcerr_mul #(.AW(V), .BW(V)) u_x   (.clk(clk), .en(en), .a(num_sig), .b(den_cnt), .p(x));
  rcerr_mul #(.AW(V), .BW(V)) u_y   (.clk(clk), .en(en), .a(den_sig), .b(num_cnt), .p(y));
  rcerr_mul #(.AW(V), .BW(V)) u_d   (.clk(clk), .en(en), .a(num_cnt), .b(den_cnt), .p(d));
  rcerr_mul #(.AW(V), .BW(V)) u_ss  (.clk(clk), .en(en), .a(num_sig), .b(den_sig), .p(ss));
  rcerr_mul #(.AW(V), .BW(V)) u_rr  (.clk(clk), .en(en), .a(ratio),   .b(ratio),   .p(rr));
  rcerr_mul #(.AW(V), .BW(V)) u_sa2 (.clk(clk), .en(en), .a(num_sig), .b(num_sig), .p(sa2));
  rcerr_mul #(.AW(V), .BW(V)) u_sb2 (.clk(clk), .en(en), .a(den_sig), .b(den_sig), .p(sb2));
  rcerr_mul #(.AW(V), .BW(V)) u_aa2 (.clk(clk), .en(en), .a(den_cnt), .b(den_cnt), .p(aa2));

  always_comb begin
    case (mode)
      MODE_SUBSET: corr = (sb2 < sa2) ? sb2 : sa2;
      MODE_FULL:   corr = ss;
      default:     corr = '0;
    endcase
  end

  assign d2 = (sa2 >= sb2) ? (sa2 - sb2) : (sb2 - sa2);

  rcerr_mul #(.AW(2*V), .BW(2*V)) u_xx (.clk(clk), .en(en), .a(x),    .b(x), .p(xx));
  rcerr_mul #(.AW(2*V), .BW(2*V)) u_yy (.clk(clk), .en(en), .a(y),    .b(y), .p(yy));
  rcerr_mul #(.AW(2*V), .BW(2*V)) u_cd (.clk(clk), .en(en), .a(corr), .b(d), .p(cd));
  rcerr_mul #(.AW(2*V), .BW(2*V)) u_dd (.clk(clk), .en(en), .a(d),    .b(d), .p(dd));

  // The correlation term never exceeds the sum of squares, so this cannot go negative.
  assign nsum = {1'b0, xx} + {1'b0, yy} - {cd, 1'b0};

  rcerr_mul #(.AW(2*V), .BW(4*V+1)) u_m1 (.clk(clk), .en(en), .a(rr5_r), .b(n5_r), .p(m1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
      ctl8_r <= '0;
    end else if (en) begin
      ctl1_r <= '{vld: in_vld, skip: (num_cnt == '0) || (den_cnt == '0)};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
      ctl8_r <= ctl7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr3_r  <= rr;
      rr4_r  <= rr3_r;
      rr5_r  <= rr4_r;
      d23_r  <= d2;
      d24_r  <= d23_r;
      d25_r  <= d24_r;
      d26_r  <= d25_r;
      d27_r  <= d26_r;
      aa3_r  <= aa2;
      aa4_r  <= aa3_r;
      n5_r   <= nsum;
      dsq5_r <= (mode == MODE_DIFF) ? DW'(aa4_r) : dd;
      dsq6_r <= dsq5_r;
      dsq7_r <= dsq6_r;
      dsq8_r <= dsq7_r;
      m8_r   <= (mode == MODE_DIFF) ? (MW'(d27_r) << (2 * FRAC_BITS)) : MW'(m1);
    end
  end

  assign m   = m8_r;
  assign dsq = dsq8_r;
  assign ctl = ctl8_r;

endmodule
`default_nettype wire

@@ design/rcerr_sqdiv.sv @@
// Bit-per-stage pipeline that finds the largest q with (q * den)^2 <= radicand.
`default_nettype none
module rcerr_sqdiv import rcerr_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [6*VALUE_BITS+2:0] m,
  input  logic [4*VALUE_BITS-1:0] dsq,
  input  pipe_ctl_t               ctl_in,
  output logic [VALUE_BITS-1:0]   q,
  output logic                    sat,
  output pipe_ctl_t               ctl_out
);

  localparam int V  = VALUE_BITS;
  localparam int NS = V + 1;
  localparam int MW = 6 * V + 3;
  localparam int DW = 4 * V;
  localparam int QW = V + 1;

  logic [MW-1:0] rem_r [NS];
  logic [MW-1:0] acc_r [NS];
  logic [QW-1:0] quo_r [NS];
  logic [DW-1:0] dsq_r [NS];
  pipe_ctl_t     ctl_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = V - s;

    logic [MW-1:0] rem_in;
    logic [MW-1:0] acc_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] dsq_in;
    pipe_ctl_t     ctl_s;
    logic [MW-1:0] dsq_w;
    logic [MW-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in = m;
      assign acc_in = '0;
      assign quo_in = '0;
      assign dsq_in = dsq;
      assign ctl_s  = ctl_in;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign acc_in = acc_r[s-1];
      assign quo_in = quo_r[s-1];
      assign dsq_in = dsq_r[s-1];
      assign ctl_s  = ctl_r[s-1];
    end

    assign dsq_w = MW'(dsq_in);
    assign trial = (acc_in << (K + 1)) + (dsq_w << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (en) begin
        ctl_r[s] <= ctl_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsq_r[s] <= dsq_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          acc_r[s] <= acc_in + (dsq_w << K);
          quo_r[s] <= quo_in | (QW'(1) << K);
        end else begin
          rem_r[s] <= rem_in;
          acc_r[s] <= acc_in;
          quo_r[s] <= quo_in;
        end
      end
    end
  end

  assign sat     = quo_r[NS-1][V];
  assign q       = sat ? '1 : quo_r[NS-1][V-1:0];
  assign ctl_out = ctl_r[NS-1];

endmodule
`default_nettype wire

@@ design/correlated_ratio_error_top.sv @@
// Top level of the correlated ratio error block with its register port.
//
// Each beat on in_bin carries one histogram bin: numerator and denominator
// contents and sigmas and the ratio content, all unsigned fixed point with
// FRAC_BITS fraction bits. Each beat on out_res carries the propagated sigma
// of the ratio with its flags, in the order the bins arrived.
// The register correlation_mode sits at address 0 of the APB-style port and
// may be written only while no bin is in flight.
// From input beat to output beat a bin passes through the limb multipliers
// that build the radicand and the squared denominator, the square-root
// divide pipeline that resolves each result bit plus a range bit, and the
// output register.
// One bin is accepted every cycle. When the receiver stalls, the whole
// pipeline holds and in_bin.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets correlation_mode to full correlation.
// The negative variance fallback cannot occur with exact arithmetic, so
// fallback_used is always zero.
`default_nettype none
module correlated_ratio_error_top import rcerr_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  rcerr_in_if.sink                 in_bin,
  rcerr_out_if.source              out_res,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int V = VALUE_BITS;

  mode_t                 mode_r;
  logic                  en;
  logic [6*V+2:0]        m;
  logic [4*V-1:0]        dsq;
  pipe_ctl_t             prep_ctl;
  pipe_ctl_t             sq_ctl;
  logic [V-1:0]          q;
  logic                  q_sat;
  logic                  out_valid_r;
  logic [V-1:0]          sigma_r;
  logic                  skip_r;
  logic                  sat_r;

  assign pready = 1'b1;
  assign prdata = paddr[CFG_ADDR_BITS-1] ? '0 : CFG_DATA_BITS'(mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[CFG_ADDR_BITS-1]) begin
      mode_r <= pwdata[1:0];
    end
  end

  assign en           = !out_valid_r || out_res.ready;
  assign in_bin.ready = en;

  rcerr_prep #(.FRAC_BITS(FRAC_BITS), .VALUE_BITS(V)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .mode    (mode_r),
    .in_vld  (in_bin.valid),
    .num_cnt (in_bin.numerator_count),
    .num_sig (in_bin.numerator_sigma),
    .den_cnt (in_bin.denominator_count),
    .den_sig (in_bin.denominator_sigma),
    .ratio   (in_bin.ratio_content),
    .m       (m),
    .dsq     (dsq),
    .ctl     (prep_ctl)
  );

  rcerr_sqdiv #(.VALUE_BITS(V)) u_sqdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .m       (m),
    .dsq     (dsq),
    .ctl_in  (prep_ctl),
    .q       (q),
    .sat     (q_sat),
    .ctl_out (sq_ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sigma_r <= sq_ctl.skip ? '0 : q;
      skip_r  <= sq_ctl.skip;
      sat_r   <= q_sat && !sq_ctl.skip;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.ratio_sigma   = sigma_r;
  assign out_res.fallback_used = 1'b0;
  assign out_res.bin_skipped   = skip_r;
  assign out_res.saturated     = sat_r;

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && skip_r |-> (sigma_r == '0) && !sat_r)
    else $error("skipped bin with nonzero sigma");

  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |-> (sigma_r == '1))
    else $error("saturated beat without full-scale sigma");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sigma_r) && $stable(skip_r) && $stable(sat_r))
    else $error("output register changed during stall");

endmodule
`default_nettype wire
